// ===== rtl/slr_pkg.sv =====
// Package: shared types and codes of the span line rasteriser.
`timescale 1ns / 1ps

package slr_pkg;

  // Command codes carried on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FIN
  } seq_state_e;

endpackage

// ===== rtl/slr_divider.sv =====
// Restoring divider: one quotient bit per cycle through a shared subtract-compare.
`timescale 1ns / 1ps

module slr_divider #(
  parameter int unsigned W = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    den_q, den_d;

  logic [W:0]      shifted;
  logic [W+1:0]    trial;
  logic            fits;
  logic            last_step;

  // Shared subtract-compare for one restoring step
  assign shifted   = {rem_q, quo_q[W-1]};
  assign trial     = {1'b0, shifted} - {2'b00, den_q};
  assign fits      = ~trial[W+1];
  assign last_step = (cnt_q == CntW'(W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/span_line_rasterizer_core.sv =====
// Top level: breaks a straight line into rectangular spans, one span per transaction.
// Usage
//   Input channel (in_valid_i / in_stall_o): command_i = start (0) loads two
//   endpoints and a colour and returns the first span; command_i = next (1)
//   returns the following span. Every input transaction yields exactly one
//   output transaction (out_valid_o / out_stall_i); span_valid_o = 0 marks
//   "no line in progress" with all other fields zero.
//   Flow: an accepted item passes through setup, the divide phase (skipped
//   for an empty result) and finish before it reaches the result register.
//   The divide phase runs the shared divider, which retires one quotient bit per
//   cycle. in_stall_o is high from acceptance until the result has been
//   moved into the output register, so one item is in flight at a time and
//   a new transaction is not taken until the previous one has left finish.
//   The output register lets a new item be accepted while a result waits.
//   If the receiver stalls, the finished span is held in the sequencer and
//   the result register until out_stall_i drops; nothing is lost.
//   Reset clears the cursor, target, colour and the line-in-progress flag
//   and empties the output register.
`timescale 1ns / 1ps

module span_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic [15:0]           line_color_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  span_valid_o,
  output logic [COORD_BITS-1:0] span_x_o,
  output logic [COORD_BITS-1:0] span_y_o,
  output logic [COORD_BITS:0]   span_width_o,
  output logic [COORD_BITS:0]   span_height_o,
  output logic [15:0]           span_color_o,
  output logic                  span_last_o
);

  import slr_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned SW = C + 1;  // span size / cursor_x width
  localparam int unsigned YW = C + 2;  // signed cursor_y width

  seq_state_e state_q, state_d;

  // Line state
  logic [SW-1:0]        cur_x_q, cur_x_d;
  logic signed [YW-1:0] cur_y_q, cur_y_d;
  logic [C-1:0]         tgt_x_q, tgt_x_d;
  logic [C-1:0]         tgt_y_q, tgt_y_d;
  logic [15:0]          color_q, color_d;
  logic                 active_q, active_d;
  // Per-span working state
  logic                 tall_q, tall_d;
  logic                 down_q, down_d;
  logic                 empty_q, empty_d;

  // Output register
  logic                 out_valid_q;
  logic                 span_valid_q;
  logic [C-1:0]         span_x_q, span_y_q;
  logic [SW-1:0]        span_width_q, span_height_q;
  logic [15:0]          span_color_q;
  logic                 span_last_q;

  logic                 in_fire;
  logic                 fin_fire;
  logic                 div_start;
  logic                 div_done;
  logic [SW-1:0]        quotient;

  // Setup arithmetic
  logic                 no_span;
  logic [SW-1:0]        adx;
  logic signed [YW-1:0] diff;
  logic                 down_now;
  logic [YW-1:0]        abs_diff;
  logic [SW-1:0]        ady;
  logic                 tall_now;
  logic [SW-1:0]        num, den;

  // Finish arithmetic
  logic [SW-1:0]        w, h;
  logic [YW-1:0]        h_ext;
  logic [YW-1:0]        top;
  logic [SW:0]          x_sum;
  logic                 last;

  assign in_fire = in_valid_i && !in_stall_o;

  // Decide whether a span exists and set up the division
  assign no_span  = !active_q || (cur_x_q > {1'b0, tgt_x_q});
  assign adx      = {1'b0, tgt_x_q} - cur_x_q + SW'(1);
  assign diff     = $signed({2'b00, tgt_y_q}) - cur_y_q;
  assign down_now = !diff[YW-1];
  assign abs_diff = down_now ? diff : -diff;
  assign ady      = abs_diff[SW-1:0] + SW'(1);
  assign tall_now = ady > adx;
  assign num      = tall_now ? ady : adx;
  assign den      = tall_now ? adx : ady;

  slr_divider #(
    .W(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Span geometry from the quotient
  assign w     = tall_q ? SW'(1) : quotient;
  assign h     = tall_q ? quotient : SW'(1);
  assign h_ext = {1'b0, h};
  assign top   = down_q ? cur_y_q : (cur_y_q - h_ext + YW'(1));
  assign x_sum = {1'b0, cur_x_q} + {1'b0, w};
  assign last  = x_sum > {2'b00, tgt_x_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SETUP;
      S_SETUP: state_d = no_span ? S_FIN : S_DIV;
      S_DIV:   if (div_done) state_d = S_FIN;
      S_FIN:   if (fin_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    fin_fire   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_SETUP: div_start = !no_span;
      S_DIV:   ;
      S_FIN:   fin_fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Line state updates
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    color_d  = color_q;
    active_d = active_q;
    tall_d   = tall_q;
    down_d   = down_q;
    empty_d  = empty_q;
    if (in_fire && command_i == CMD_START) begin
      if (x_start_i > x_end_i) begin
        cur_x_d = {1'b0, x_end_i};
        cur_y_d = $signed({2'b00, y_end_i});
        tgt_x_d = x_start_i;
        tgt_y_d = y_start_i;
      end else begin
        cur_x_d = {1'b0, x_start_i};
        cur_y_d = $signed({2'b00, y_start_i});
        tgt_x_d = x_end_i;
        tgt_y_d = y_end_i;
      end
      color_d  = line_color_i;
      active_d = 1'b1;
    end
    if (state_q == S_SETUP) begin
      empty_d = no_span;
      tall_d  = tall_now;
      down_d  = down_now;
      if (no_span) active_d = 1'b0;
    end
    if (fin_fire && !empty_q) begin
      cur_x_d = x_sum[SW-1:0];
      cur_y_d = down_q ? (cur_y_q + h_ext) : (cur_y_q - h_ext);
      if (last) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
      tall_q   <= 1'b0;
      down_q   <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      color_q  <= color_d;
      active_q <= active_d;
      tall_q   <= tall_d;
      down_q   <= down_d;
      empty_q  <= empty_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      span_valid_q  <= !empty_q;
      span_x_q      <= empty_q ? '0 : cur_x_q[C-1:0];
      span_y_q      <= empty_q ? '0 : top[C-1:0];
      span_width_q  <= empty_q ? '0 : w;
      span_height_q <= empty_q ? '0 : h;
      span_color_q  <= empty_q ? '0 : color_q;
      span_last_q   <= empty_q ? 1'b0 : last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_valid_o  = span_valid_q;
  assign span_x_o      = span_x_q;
  assign span_y_o      = span_y_q;
  assign span_width_o  = span_width_q;
  assign span_height_o = span_height_q;
  assign span_color_o  = span_color_q;
  assign span_last_o   = span_last_q;

  // Checks
  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_SETUP)
    else $error("accepted transaction did not enter setup");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result register loaded outside finish");

  a_span_thin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && span_valid_q |-> span_width_q == SW'(1) || span_height_q == SW'(1))
    else $error("span is neither one column nor one row");

  a_busy_no_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> in_stall_o)
    else $error("input taken while dividing");

endmodule
